### rtl/core/prime_chain_sieve_offsets_defines.svh
// Assertion macros for the prime chain sieve offset block.
// Included by the RTL files that carry assertions; expects clk and rst in scope.
`ifndef PRIME_CHAIN_SIEVE_OFFSETS_DEFINES_SVH
`define PRIME_CHAIN_SIEVE_OFFSETS_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PCSO_ASSERT_HOLD(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define PCSO_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/pcso_pkg.sv
// Package for the prime chain sieve offset block: sequencer states and fixed widths.
// No dependencies.
`default_nettype none

package pcso_pkg;

  localparam int CFG_W = 6;
  localparam int IDX_W = 5;
  localparam logic [CFG_W-1:0] LAYER_COUNT_RESET = 6'd10;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b00000001,
    ST_RES_DIV  = 8'b00000010,
    ST_EUC_TEST = 8'b00000100,
    ST_EUC_DIV  = 8'b00001000,
    ST_EUC_MUL  = 8'b00010000,
    ST_EUC_UPD  = 8'b00100000,
    ST_EMIT     = 8'b01000000,
    ST_LAY_MUL  = 8'b10000000
  } state_t;

endpackage

`default_nettype wire

### rtl/core/prime_chain_sieve_offsets.sv
// Start offsets for sieving prime chains: modular inverse by extended Euclid, then one
// offset pair per chain layer. Depends on pcso_pkg and prime_chain_sieve_offsets_defines.svh.
`default_nettype none

`include "prime_chain_sieve_offsets_defines.svh"

// One prime is taken at a time; in_stall stays high from the transfer until the last
// layer result has been handed to the output register, or until the residue is found
// to be zero. All arithmetic but the negation p - x runs through a single add-and-reduce
// unit (a + b + carry, less the modulus if the sum reaches it), which serves as one
// restoring division step, one doubling or one addition of a shift-and-add modular
// multiply, or the coefficient update. The residue is first reduced modulo the prime;
// each Euclid step then runs a division, a multiply and an update, and each further
// layer runs a multiply and a load of the output register.
// The output register lets the sequencer work on the next layer while a result waits
// to be taken.
module prime_chain_sieve_offsets
  import pcso_pkg::*;
#(
  parameter int MAX_LAYERS = 32,
  parameter int PRIME_BITS = 31
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PRIME_BITS-1:0] prime,
  input  wire logic [PRIME_BITS-1:0] primorial_residue,
  input  wire logic [PRIME_BITS-1:0] half_inverse,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [IDX_W-1:0]           layer_index,
  output logic [PRIME_BITS-1:0]      first_kind_offset,
  output logic [PRIME_BITS-1:0]      second_kind_offset,
  output logic                       last_layer
);

  localparam int P      = PRIME_BITS;
  localparam int STEP_W = $clog2(P);
  localparam int CNT_W  = $clog2(MAX_LAYERS + 1);

  state_t state;

  logic [CFG_W-1:0]  layer_count;
  logic [CNT_W-1:0]  count_eff;
  logic [CNT_W-1:0]  lay;
  logic [P-1:0]      p_reg;
  logic [P-1:0]      hinv;
  logic [P-1:0]      r0;
  logic [P-1:0]      r1;
  logic [P-1:0]      s0;
  logic [P-1:0]      s1;
  logic [P-1:0]      dvd;
  logic [P-1:0]      rem;
  logic [P-1:0]      mlr;
  logic [P-1:0]      acc;
  logic [P-1:0]      f;
  logic [STEP_W-1:0] cnt;
  logic              phase;

  // Shared add-and-reduce unit.
  logic [P-1:0] unit_a;
  logic [P-1:0] unit_b;
  logic [P-1:0] unit_m;
  logic         unit_cin;
  logic [P:0]   unit_sum;
  logic [P:0]   unit_diff;
  logic         unit_ge;
  logic [P-1:0] unit_res;

  logic [P-1:0] neg_in;
  logic [P-1:0] neg;
  logic [CFG_W:0] count_wide;
  logic [CNT_W-1:0] count_clamped;
  logic step_last;
  logic bit_done;
  logic out_free;
  logic is_last;
  logic mul_busy;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  always_comb begin
    count_wide = {1'b0, layer_count};
    if (count_wide > (CFG_W + 1)'(MAX_LAYERS)) begin
      count_wide = (CFG_W + 1)'(MAX_LAYERS);
    end
    count_clamped = CNT_W'(count_wide);
  end

  assign step_last = (cnt == STEP_W'(P - 1));
  assign bit_done  = phase || !mlr[P-1];
  assign out_free  = !out_valid || !out_stall;
  assign is_last   = (lay == count_eff - CNT_W'(1));
  assign mul_busy  = (state == ST_EUC_MUL) || (state == ST_LAY_MUL);

  // The subtrahend is always below the prime, so p - x stays in P bits.
  assign neg_in = (state == ST_EUC_UPD) ? acc : f;
  assign neg    = p_reg - neg_in;

  always_comb begin
    unit_a   = rem;
    unit_b   = rem;
    unit_cin = dvd[P-1];
    unit_m   = p_reg;
    unique case (state)
      ST_EUC_DIV: begin
        unit_m = r1;
      end
      ST_EUC_MUL, ST_LAY_MUL: begin
        unit_a   = acc;
        unit_cin = 1'b0;
        if (phase) begin
          unit_b = (state == ST_EUC_MUL) ? s1 : f;
        end else begin
          unit_b = acc;
        end
      end
      ST_EUC_UPD: begin
        unit_a   = s0;
        unit_b   = neg;
        unit_cin = 1'b0;
      end
      default: begin
        unit_a = rem;
      end
    endcase
  end

  assign unit_sum  = {1'b0, unit_a} + {1'b0, unit_b} + {{P{1'b0}}, unit_cin};
  assign unit_ge   = (unit_sum >= {1'b0, unit_m});
  assign unit_diff = unit_sum - {1'b0, unit_m};
  assign unit_res  = unit_ge ? unit_diff[P-1:0] : unit_sum[P-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      layer_count <= LAYER_COUNT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        layer_count <= cfg_data;
      end
      // While emitting, the output register is refilled below instead.
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            p_reg     <= prime;
            hinv      <= half_inverse;
            dvd       <= primorial_residue;
            rem       <= '0;
            cnt       <= '0;
            count_eff <= count_clamped;
            if (prime > P'(1) && count_clamped != '0) begin
              state <= ST_RES_DIV;
            end
          end
        end
        ST_RES_DIV: begin
          rem <= unit_res;
          dvd <= {dvd[P-2:0], unit_ge};
          cnt <= cnt + STEP_W'(1);
          if (step_last) begin
            r0 <= p_reg;
            r1 <= unit_res;
            s0 <= '0;
            s1 <= P'(1);
            state <= (unit_res == '0) ? ST_IDLE : ST_EUC_TEST;
          end
        end
        ST_EUC_TEST: begin
          if (r1 > P'(1)) begin
            dvd   <= r0;
            rem   <= '0;
            cnt   <= '0;
            state <= ST_EUC_DIV;
          end else begin
            f     <= s1;
            lay   <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EUC_DIV: begin
          rem <= unit_res;
          dvd <= {dvd[P-2:0], unit_ge};
          if (step_last) begin
            // The quotient is complete with this step's bit; it becomes the multiplier.
            mlr   <= {dvd[P-2:0], unit_ge};
            acc   <= '0;
            cnt   <= '0;
            phase <= 1'b0;
            state <= ST_EUC_MUL;
          end else begin
            cnt <= cnt + STEP_W'(1);
          end
        end
        ST_EUC_MUL, ST_LAY_MUL: begin
          acc <= unit_res;
          if (bit_done) begin
            phase <= 1'b0;
            mlr   <= mlr << 1;
            cnt   <= cnt + STEP_W'(1);
            if (step_last) begin
              if (state == ST_EUC_MUL) begin
                state <= ST_EUC_UPD;
              end else begin
                f     <= unit_res;
                state <= ST_EMIT;
              end
            end
          end else begin
            phase <= 1'b1;
          end
        end
        ST_EUC_UPD: begin
          // Coefficients are kept reduced modulo the prime: s2 = s0 - q * s1 mod p.
          r0    <= r1;
          r1    <= rem;
          s0    <= s1;
          s1    <= unit_res;
          state <= ST_EUC_TEST;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            layer_index        <= IDX_W'(lay);
            first_kind_offset  <= f;
            second_kind_offset <= neg;
            last_layer         <= is_last;
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              mlr   <= hinv;
              acc   <= '0;
              cnt   <= '0;
              phase <= 1'b0;
              lay   <= lay + CNT_W'(1);
              state <= ST_LAY_MUL;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PCSO_ASSERT_IMPLY(a_div_rem_below, state == ST_EUC_DIV, rem < r1, "remainder not below divisor")
  `PCSO_ASSERT_IMPLY(a_mul_acc_below, mul_busy, acc < p_reg, "multiply accumulator not reduced")
  `PCSO_ASSERT_IMPLY(a_s0_below, state == ST_EUC_TEST, s0 < p_reg, "Euclid s0 not reduced")
  `PCSO_ASSERT_IMPLY(a_s1_below, state == ST_EUC_TEST, s1 < p_reg, "Euclid s1 not reduced")
  `PCSO_ASSERT_IMPLY(a_offset_below, state == ST_EMIT, f < p_reg, "offset not reduced")
  `PCSO_ASSERT_IMPLY(a_layer_below, state == ST_EMIT, lay < count_eff, "layer out of range")

endmodule

`default_nettype wire

### verif/tb_prime_chain_sieve_offsets.sv
// Self-checking testbench for prime_chain_sieve_offsets: a random and directed stream of
// sieving primes under random idling, with the offset pairs predicted and checked in order.
// Depends on pcso_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_prime_chain_sieve_offsets;
  import pcso_pkg::*;

  localparam int PW = 31;
  localparam int LAYER_CAP = 32;
  localparam longint unsigned PMAX = 64'h7FFF_FFFF;
  // Worst case for one prime with every layer, rounded up.
  localparam int SETTLE = 8000;

  typedef struct packed {
    logic [PW-1:0] p;
    logic [PW-1:0] res;
    logic [PW-1:0] hinv;
  } sieve_prime_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [PW-1:0]    fk;
    logic [PW-1:0]    sk;
    logic             fin;
  } layer_offsets_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PW-1:0] prime = '0;
  logic [PW-1:0] primorial_residue = '0;
  logic [PW-1:0] half_inverse = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] layer_index;
  logic [PW-1:0] first_kind_offset;
  logic [PW-1:0] second_kind_offset;
  logic last_layer;

  sieve_prime_t   primes_to_send[$];
  layer_offsets_t offsets_due[$];
  logic [CFG_W-1:0] layers_shadow = LAYER_COUNT_RESET;
  logic in_fired = 1'b0;
  int error_count = 0;
  int errors_shown = 0;

  prime_chain_sieve_offsets i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .prime              (prime),
    .primorial_residue  (primorial_residue),
    .half_inverse       (half_inverse),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .layer_index        (layer_index),
    .first_kind_offset  (first_kind_offset),
    .second_kind_offset (second_kind_offset),
    .last_layer         (last_layer)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Extended Euclid, stopping once the remainder is at most one; the coefficient held
  // then is folded into [0, m).
  function automatic longint unsigned chain_start(longint unsigned a, longint unsigned m);
    longint r0, r1, r2, s0, s1, s2, q, mm;
    r0 = m;
    r1 = a;
    s0 = 0;
    s1 = 1;
    mm = m;
    while (r1 > 1) begin
      q = r0 / r1;
      r2 = r0 - q * r1;
      s2 = s0 - q * s1;
      r0 = r1;
      r1 = r2;
      s0 = s1;
      s1 = s2;
    end
    s1 = s1 % mm;
    if (s1 < 0) s1 += mm;
    return s1;
  endfunction

  task automatic predict_offsets(input sieve_prime_t it);
    longint unsigned p, r, h, f, cnt, l, d;
    layer_offsets_t e;
    p = it.p;
    r = it.res;
    h = it.hinv;
    cnt = layers_shadow;
    if (p < 2) return;
    r = r % p;
    if (r == 0) return;
    if (cnt > LAYER_CAP) cnt = LAYER_CAP;
    if (cnt == 0) return;
    f = chain_start(r, p);
    for (l = 0; l < cnt; l++) begin
      d = p - f;
      e.idx = l[IDX_W-1:0];
      e.fk = f[PW-1:0];
      e.sk = d[PW-1:0];
      e.fin = (l + 1 == cnt);
      offsets_due.push_back(e);
      f = (f * h) % p;
    end
  endtask

  function automatic bit is_prime(longint unsigned n);
    longint unsigned d;
    if (n < 2) return 0;
    if (n % 2 == 0) return n == 2;
    for (d = 3; d * d <= n; d += 2)
      if (n % d == 0) return 0;
    return 1;
  endfunction

  function automatic longint unsigned rand_prime(int unsigned lim);
    longint unsigned n;
    n = $urandom_range(lim, 3) | 1;
    while (!is_prime(n)) begin
      n += 2;
      if (n > PMAX) n = 3;
    end
    return n;
  endfunction

  function automatic void queue_prime(longint unsigned p, longint unsigned res,
                                      longint unsigned hinv);
    sieve_prime_t it;
    it.p = p[PW-1:0];
    it.res = res[PW-1:0];
    it.hinv = hinv[PW-1:0];
    primes_to_send.push_back(it);
  endfunction

  // Mostly real primes with a proper inverse of two, the rest unreduced residues,
  // wrong inverses and plain noise.
  function automatic void queue_random_prime();
    int unsigned r;
    longint unsigned p, res;
    r = $urandom_range(99, 0);
    if (r < 45) p = rand_prime(65535);
    else if (r < 60) p = rand_prime(32'h00FF_FFFF);
    else p = rand_prime(PMAX);
    if (r < 80) begin
      queue_prime(p, $urandom_range(p - 1, 1), (p + 1) / 2);
    end else if (r < 87) begin
      queue_prime($urandom() & PMAX, $urandom() & PMAX, $urandom() & PMAX);
    end else if (r < 94) begin
      p = rand_prime(4095);
      if ($urandom_range(3, 0) == 0) res = p * $urandom_range(PMAX / p, 1);
      else res = $urandom() & PMAX;
      queue_prime(p, res, (p + 1) / 2);
    end else begin
      queue_prime(p, $urandom_range(p - 1, 1), $urandom() & PMAX);
    end
  endfunction

  // Idle run length: usually none, sometimes a short run, now and then a long one.
  function automatic int idle_len(int busy_pct);
    int r;
    r = $urandom_range(99, 0);
    if (r >= busy_pct) return 0;
    if (r < busy_pct * 8 / 10) return $urandom_range(3, 1);
    return $urandom_range(60, 12);
  endfunction

  // Sender: holds a payload until its transfer, then may idle before the next one.
  int tx_gap = 0;
  int tx_win = 0;
  bit tx_calm = 1'b0;
  sieve_prime_t tx_item;

  always @(negedge clk) begin
    if (tx_win == 0) begin
      tx_calm = ($urandom_range(3, 0) == 0);
      tx_win = $urandom_range(400, 50);
    end else begin
      tx_win--;
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (primes_to_send.size() != 0) begin
        tx_item = primes_to_send.pop_front();
        prime <= tx_item.p;
        primorial_residue <= tx_item.res;
        half_inverse <= tx_item.hinv;
        in_valid <= 1'b1;
        tx_gap = tx_calm ? 0 : idle_len(40);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern.
  int rx_hold = 0;
  int rx_win = 0;
  bit rx_calm = 1'b0;

  always @(negedge clk) begin
    if (rx_win == 0) begin
      rx_calm = ($urandom_range(3, 0) == 0);
      rx_win = $urandom_range(400, 50);
    end else begin
      rx_win--;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else begin
      rx_hold = rx_calm ? 0 : idle_len(30);
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_fired <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall)
      predict_offsets('{p: prime, res: primorial_residue, hinv: half_inverse});
  end

  always @(posedge clk) begin
    layer_offsets_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{idx: layer_index, fk: first_kind_offset, sk: second_kind_offset,
              fin: last_layer};
      if (offsets_due.size() == 0) begin
        error_count++;
        if (errors_shown < 10)
          $display("ERROR %0t: unexpected result layer %0d first %0d second %0d last %0b",
                   $realtime, got.idx, got.fk, got.sk, got.fin);
        errors_shown++;
      end else begin
        want = offsets_due.pop_front();
        if (got.idx !== want.idx || got.fk !== want.fk || got.sk !== want.sk ||
            got.fin !== want.fin) begin
          error_count++;
          if (errors_shown < 10)
            $display("ERROR %0t: expected layer %0d first %0d second %0d last %0b, %s",
                     $realtime, want.idx, want.fk, want.sk, want.fin,
                     $sformatf("got layer %0d first %0d second %0d last %0b",
                               got.idx, got.fk, got.sk, got.fin));
          errors_shown++;
        end
      end
    end
  end

  task automatic write_layers(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    layers_shadow = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Lets the sender run dry, waits out every result, then gives a prime that yields
  // nothing time to finish before the register may change.
  task automatic drain();
    do @(posedge clk);
    while (primes_to_send.size() != 0 || in_valid || offsets_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int layer_set[8];
    int batch[8];
    int ph, n;
    layer_set = '{0, 63, 1, 32, 31, 33, -1, 10};
    batch = '{4, 20, 40, 30, 25, 10, 30, 45};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed primes under the reset layer count.
    queue_prime(3, 1, 2);
    queue_prime(3, 2, 2);
    queue_prime(PMAX, PMAX - 1, 64'h4000_0000);
    queue_prime(PMAX, 1, 64'h4000_0000);
    queue_prime(PMAX, PMAX, PMAX);
    queue_prime(0, 5, 1);
    queue_prime(1, PMAX, PMAX);
    queue_prime(7, 0, 4);
    queue_prime(7, 14, 4);
    queue_prime(7, PMAX, 4);
    queue_prime(64'h7FFF_FFFE, 12345, 64'h3FFF_FFFF);
    queue_prime(15, 6, 8);
    queue_prime(2, 1, 1);
    queue_prime(101, 17, 0);
    queue_prime(101, 17, PMAX);
    queue_prime(65521, 65520, 32761);
    queue_prime(64'h5555_5555, 64'h2AAA_AAAA, 64'h2AAA_AAAB);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      write_layers(layer_set[ph] < 0 ? CFG_W'($urandom_range(LAYER_CAP, 1))
                                     : CFG_W'(layer_set[ph]));
      // More layers than the block keeps are clamped to its maximum; the top prime runs under that count.
      if (layer_set[ph] == 63) begin
        queue_prime(PMAX, 2, 64'h4000_0000);
        queue_prime(3, 1, 2);
      end
      for (n = 0; n < batch[ph]; n++) queue_random_prime();
      drain();
    end

    if (offsets_due.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("** prime_chain_sieve_offsets: PASSED **");
    end else begin
      $display("** prime_chain_sieve_offsets: FAILED **");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("** prime_chain_sieve_offsets: FAILED **");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/pcso_pkg.sv
rtl/core/prime_chain_sieve_offsets.sv
verif/tb_prime_chain_sieve_offsets.sv
